// File: rtl/greenhouse_climate_controller_macros.svh
// ----------------------------------------------------------------------------
// Greenhouse climate controller assertion macros
// Shared property wrappers for the checker; each takes a label, the clock,
// the active-low reset, a trigger condition and the expected consequence.
// ----------------------------------------------------------------------------
`ifndef GREENHOUSE_CLIMATE_CONTROLLER_MACROS_SVH
`define GREENHOUSE_CLIMATE_CONTROLLER_MACROS_SVH

// The consequence must hold in the same cycle as the trigger.
`define GCC_ASSERT_IMPL(label, clk, rst_n, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
		else $error("%m: check failed");

// The consequence must hold in the cycle after the trigger.
`define GCC_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
		else $error("%m: check failed");

`endif

// File: rtl/gcc_pkg.sv
// ----------------------------------------------------------------------------
// Greenhouse climate controller package
// Register indexes, reset values, time-of-day constants and the structs that
// move configuration, samples and results between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gcc_pkg;

	localparam int TIME_WIDTH_DEF = 32;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMP_HIGH,
		REG_TEMP_LOW,
		REG_LIGHT_THR,
		REG_HUM_LIMIT,
		REG_SOIL_IDLE,
		REG_PUMP_RUN,
		REG_PUMP_REST
	} reg_idx_t;

	localparam logic signed [7:0] TEMP_HIGH_RST = 8'sd29;
	localparam logic signed [7:0] TEMP_LOW_RST  = 8'sd28;
	localparam logic [9:0]  LIGHT_THR_RST       = 10'd500;
	localparam logic [6:0]  HUM_LIMIT_RST       = 7'd60;
	localparam logic [9:0]  SOIL_IDLE_RST       = 10'd100;
	localparam logic [15:0] PUMP_RUN_RST        = 16'd2000;
	localparam logic [15:0] PUMP_REST_RST       = 16'd4000;

	localparam logic signed [7:0] HELD_TEMP_RST = 8'sd25;
	localparam logic [6:0]        HELD_HUM_RST  = 7'd50;

	localparam int MINUTE_MS        = 60000;
	localparam int MINUTES_PER_HOUR = 60;
	localparam int LAST_HOUR        = 23;
	localparam int LAMP_HOUR_ON     = 10;
	localparam int LAMP_HOUR_OFF    = 22;
	localparam int PUMP_NIGHT_AFTER = 22;
	localparam int PUMP_NIGHT_UNTIL = 10;

	typedef struct packed {
		logic signed [7:0] temp_high;
		logic signed [7:0] temp_low;
		logic [9:0]        light_threshold;
		logic [6:0]        air_humidity_limit;
		logic [9:0]        soil_idle_limit;
		logic [15:0]       pump_run_ms;
		logic [15:0]       pump_rest_ms;
	} cfg_t;

	typedef struct packed {
		logic [31:0]       now_ms;
		logic signed [7:0] temperature;
		logic              temperature_valid;
		logic [6:0]        air_humidity;
		logic              air_humidity_valid;
		logic [9:0]        soil_moisture;
		logic [9:0]        light_level;
	} sample_t;

	typedef struct packed {
		logic       heater_on;
		logic       fan_on;
		logic       pump_on;
		logic       lamp_on;
		logic [4:0] hour_now;
		logic [5:0] minute_now;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/gcc_if.sv
// ----------------------------------------------------------------------------
// Greenhouse climate controller channels
// Valid/ready stream interfaces for the sensor sample word and the actuator
// result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface gcc_in_if;
	logic              valid;
	logic              ready;
	logic [31:0]       now_ms;
	logic signed [7:0] temperature;
	logic              temperature_valid;
	logic [6:0]        air_humidity;
	logic              air_humidity_valid;
	logic [9:0]        soil_moisture;
	logic [9:0]        light_level;

	modport source (
		output valid, now_ms, temperature, temperature_valid,
		       air_humidity, air_humidity_valid, soil_moisture, light_level,
		input  ready
	);
	modport sink (
		input  valid, now_ms, temperature, temperature_valid,
		       air_humidity, air_humidity_valid, soil_moisture, light_level,
		output ready
	);
endinterface

interface gcc_out_if;
	logic       valid;
	logic       ready;
	logic       heater_on;
	logic       fan_on;
	logic       pump_on;
	logic       lamp_on;
	logic [4:0] hour_now;
	logic [5:0] minute_now;

	modport source (
		output valid, heater_on, fan_on, pump_on, lamp_on, hour_now, minute_now,
		input  ready
	);
	modport sink (
		input  valid, heater_on, fan_on, pump_on, lamp_on, hour_now, minute_now,
		output ready
	);
endinterface

`default_nettype wire

// File: rtl/gcc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Greenhouse climate controller configuration registers
// Write-only register file for thresholds and pump timing.
// ----------------------------------------------------------------------------
`default_nettype none

module gcc_cfg_regs import gcc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_high          <= TEMP_HIGH_RST;
			cfg_q.temp_low           <= TEMP_LOW_RST;
			cfg_q.light_threshold    <= LIGHT_THR_RST;
			cfg_q.air_humidity_limit <= HUM_LIMIT_RST;
			cfg_q.soil_idle_limit    <= SOIL_IDLE_RST;
			cfg_q.pump_run_ms        <= PUMP_RUN_RST;
			cfg_q.pump_rest_ms       <= PUMP_REST_RST;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_TEMP_HIGH: cfg_q.temp_high          <= $signed(wr_data[7:0]);
				REG_TEMP_LOW:  cfg_q.temp_low           <= $signed(wr_data[7:0]);
				REG_LIGHT_THR: cfg_q.light_threshold    <= wr_data[9:0];
				REG_HUM_LIMIT: cfg_q.air_humidity_limit <= wr_data[6:0];
				REG_SOIL_IDLE: cfg_q.soil_idle_limit    <= wr_data[9:0];
				REG_PUMP_RUN:  cfg_q.pump_run_ms        <= wr_data[15:0];
				REG_PUMP_REST: cfg_q.pump_rest_ms       <= wr_data[15:0];
				default: begin
					// Writes to unused indexes are dropped.
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/gcc_core.sv
// ----------------------------------------------------------------------------
// Greenhouse climate controller decision core
// Holds the sensor readings, the time-of-day clock and the pump cycle state,
// and forms the actuator word for the sample that is being retired.
// ----------------------------------------------------------------------------
`default_nettype none

module gcc_core import gcc_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  sample_t smp,
	input  cfg_t    cfg,
	output result_t res
);

	typedef logic [TIME_WIDTH-1:0] stamp_t;

	logic signed [7:0] held_temp_q;
	logic [6:0]        held_hum_q;
	stamp_t            last_minute_q;
	logic [5:0]        minute_q;
	logic [4:0]        hour_q;
	logic              in_cycle_q;
	logic              pump_q;
	stamp_t            last_switch_q;

	logic signed [7:0] held_temp_n;
	logic [6:0]        held_hum_n;
	stamp_t            now;
	stamp_t            minute_el;
	stamp_t            pump_el;
	logic              minute_adv;
	logic [5:0]        minute_inc;
	logic [4:0]        hour_inc;
	logic [5:0]        minute_n;
	logic [4:0]        hour_n;
	logic              night;
	logic              pump_idle;
	logic              pump_n;
	logic              in_cycle_n;
	logic              switch_n;
	logic              heat_t;
	logic              fan_t;
	logic              humid;

	always_comb begin
		held_temp_n = smp.temperature_valid ? smp.temperature : held_temp_q;
		held_hum_n  = smp.air_humidity_valid ? smp.air_humidity : held_hum_q;

		// All elapsed times wrap modulo the stamp width.
		now        = TIME_WIDTH'(smp.now_ms);
		minute_el  = now - last_minute_q;
		pump_el    = now - last_switch_q;
		minute_adv = minute_el >= TIME_WIDTH'(MINUTE_MS);

		minute_inc = minute_q + 6'd1;
		hour_inc   = (hour_q >= 5'(LAST_HOUR)) ? 5'd0 : hour_q + 5'd1;
		minute_n   = minute_q;
		hour_n     = hour_q;
		if (minute_adv) begin
			if (minute_inc >= 6'(MINUTES_PER_HOUR)) begin
				minute_n = 6'd0;
				hour_n   = hour_inc;
			end else begin
				minute_n = minute_inc;
			end
		end

		if (held_temp_n > cfg.temp_high) begin
			heat_t = 1'b0;
			fan_t  = 1'b1;
		end else if (held_temp_n < cfg.temp_low) begin
			heat_t = 1'b1;
			fan_t  = 1'b0;
		end else begin
			heat_t = 1'b0;
			fan_t  = 1'b0;
		end
		humid = held_hum_n > cfg.air_humidity_limit;

		night     = (hour_n > 5'(PUMP_NIGHT_AFTER)) || (hour_n <= 5'(PUMP_NIGHT_UNTIL));
		pump_idle = (smp.soil_moisture <= cfg.soil_idle_limit) && night;
		pump_n     = pump_q;
		in_cycle_n = in_cycle_q;
		switch_n   = 1'b0;
		if (pump_idle) begin
			pump_n     = 1'b0;
			in_cycle_n = 1'b0;
		end else if (!in_cycle_q) begin
			pump_n     = 1'b1;
			in_cycle_n = 1'b1;
			switch_n   = 1'b1;
		end else if (pump_q) begin
			if (pump_el >= TIME_WIDTH'(cfg.pump_run_ms)) begin
				pump_n   = 1'b0;
				switch_n = 1'b1;
			end
		end else if (pump_el >= TIME_WIDTH'(cfg.pump_rest_ms)) begin
			pump_n   = 1'b1;
			switch_n = 1'b1;
		end

		res.heater_on  = heat_t | humid;
		res.fan_on     = fan_t | humid;
		res.pump_on    = pump_n;
		res.lamp_on    = (smp.light_level < cfg.light_threshold) &&
		                 (hour_n < 5'(LAMP_HOUR_OFF)) && (hour_n >= 5'(LAMP_HOUR_ON));
		res.hour_now   = hour_n;
		res.minute_now = minute_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_temp_q   <= HELD_TEMP_RST;
			held_hum_q    <= HELD_HUM_RST;
			last_minute_q <= '0;
			minute_q      <= '0;
			hour_q        <= '0;
			in_cycle_q    <= 1'b0;
			pump_q        <= 1'b0;
			last_switch_q <= '0;
		end else if (step) begin
			held_temp_q <= held_temp_n;
			held_hum_q  <= held_hum_n;
			if (minute_adv) begin
				last_minute_q <= now;
			end
			minute_q   <= minute_n;
			hour_q     <= hour_n;
			in_cycle_q <= in_cycle_n;
			pump_q     <= pump_n;
			if (switch_n) begin
				last_switch_q <= now;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/greenhouse_climate_controller.sv
// ----------------------------------------------------------------------------
// Greenhouse climate controller
// Turns sensor samples into heater, fan, pump and lamp drives with an
// internal time-of-day clock.
// ----------------------------------------------------------------------------
// The block takes one sample word per clock cycle while the result side
// does not stall, and returns exactly one actuator word for each, in order.
// A sample is captured in an input register and is then retired through the
// decision core into the result register, which drives the port; the
// sustained rate is one word per cycle, set by the combinational compare
// and subtract logic of the core, and backpressure from the result side
// holds the input register and then the sample channel. The time-of-day
// clock advances one minute when at least 60000 ms have passed on the
// sample stamps since the last advance; stamps and pump intervals are
// measured modulo two to the TIME_WIDTH.
`default_nettype none

module greenhouse_climate_controller import gcc_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	gcc_in_if.sink                sample,
	gcc_out_if.source             drive,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	cfg_t    cfg;
	sample_t smp_in;
	sample_t smp_s1;
	logic    valid_s1;
	result_t res;
	result_t res_q;
	logic    res_valid_q;
	logic    retire;

	gcc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	always_comb begin
		smp_in.now_ms             = sample.now_ms;
		smp_in.temperature        = sample.temperature;
		smp_in.temperature_valid  = sample.temperature_valid;
		smp_in.air_humidity       = sample.air_humidity;
		smp_in.air_humidity_valid = sample.air_humidity_valid;
		smp_in.soil_moisture      = sample.soil_moisture;
		smp_in.light_level        = sample.light_level;
	end

	// A captured word moves on whenever the result register is free or drains.
	assign retire       = valid_s1 && (!res_valid_q || drive.ready);
	assign sample.ready = !valid_s1 || retire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			smp_s1 <= smp_in;
		end
	end

	gcc_core #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (retire),
		.smp    (smp_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || drive.ready) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (retire) begin
			res_q <= res;
		end
	end

	assign drive.valid      = res_valid_q;
	assign drive.heater_on  = res_q.heater_on;
	assign drive.fan_on     = res_q.fan_on;
	assign drive.pump_on    = res_q.pump_on;
	assign drive.lamp_on    = res_q.lamp_on;
	assign drive.hour_now   = res_q.hour_now;
	assign drive.minute_now = res_q.minute_now;

endmodule

`default_nettype wire

// File: rtl/gcc_checker.sv
// ----------------------------------------------------------------------------
// Greenhouse climate controller port checker
// Watches the result channel for stall behavior and for clock and lamp
// values that the controller can never produce.
// ----------------------------------------------------------------------------
`default_nettype none

`include "greenhouse_climate_controller_macros.svh"

module gcc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       valid,
	input logic       ready,
	input logic       heater_on,
	input logic       fan_on,
	input logic       pump_on,
	input logic       lamp_on,
	input logic [4:0] hour_now,
	input logic [5:0] minute_now
);

	logic [14:0] word;

	assign word = {heater_on, fan_on, pump_on, lamp_on, hour_now, minute_now};

	`GCC_ASSERT_NEXT(a_stall_keeps_valid, clk, arst_n, valid && !ready, valid)
	`GCC_ASSERT_NEXT(a_stall_keeps_word, clk, arst_n, valid && !ready, $stable(word))
	`GCC_ASSERT_IMPL(a_hour_range, clk, arst_n, valid, hour_now <= 5'd23)
	`GCC_ASSERT_IMPL(a_minute_range, clk, arst_n, valid, minute_now <= 6'd59)
	// The lamp is only allowed during the day window.
	`GCC_ASSERT_IMPL(a_lamp_daytime, clk, arst_n, valid && lamp_on, (hour_now >= 5'd10) && (hour_now <= 5'd21))

endmodule

bind greenhouse_climate_controller gcc_checker u_gcc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.valid      (drive.valid),
	.ready      (drive.ready),
	.heater_on  (drive.heater_on),
	.fan_on     (drive.fan_on),
	.pump_on    (drive.pump_on),
	.lamp_on    (drive.lamp_on),
	.hour_now   (drive.hour_now),
	.minute_now (drive.minute_now)
);

`default_nettype wire

// File: sim/climate_checker.sv
// ----------------------------------------------------------------------------
// Greenhouse climate controller checker
// Watches the sample, drive and register write ports. It keeps its own copy
// of the settings and controller state, predicts the drive word for every
// accepted sample and compares each drive word, field by field, in order.
// ----------------------------------------------------------------------------
module climate_checker import gcc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	gcc_in_if                     sample,
	gcc_out_if                    drive,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output int                    pending_drives,
	output int                    mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRINT_CAP = 60;

	cfg_t              settings;
	logic signed [7:0] held_temp;
	logic [6:0]        held_hum;
	logic [31:0]       minute_stamp;
	logic [31:0]       pump_stamp;
	logic [5:0]        minute;
	logic [4:0]        hour;
	logic              watering;
	logic              pump;
	result_t           expected_drives[$];

	// Only the first PRINT_CAP mismatches are printed; all of them are counted.
	task automatic report(string text);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("drive mismatch at %0t ns: %s", $time, text);
	endtask

	// Advances the controller state by one sample word and returns its drive word.
	function automatic result_t climate_decide(sample_t s);
		result_t     r;
		logic        heat;
		logic        cool;
		logic        humid;
		logic        night;
		logic [31:0] since;
		if (s.temperature_valid)
			held_temp = s.temperature;
		if (s.air_humidity_valid)
			held_hum = s.air_humidity;

		since = s.now_ms - minute_stamp;
		if (since >= 32'(MINUTE_MS)) begin
			minute_stamp = s.now_ms;
			if (minute == 6'(MINUTES_PER_HOUR - 1)) begin
				minute = '0;
				hour = (hour == 5'(LAST_HOUR)) ? '0 : hour + 5'd1;
			end else begin
				minute = minute + 6'd1;
			end
		end

		heat = 1'b0;
		cool = 1'b0;
		if ($signed(held_temp) > $signed(settings.temp_high))
			cool = 1'b1;
		else if ($signed(held_temp) < $signed(settings.temp_low))
			heat = 1'b1;

		night = (hour > 5'(PUMP_NIGHT_AFTER)) || (hour <= 5'(PUMP_NIGHT_UNTIL));
		if (s.soil_moisture <= settings.soil_idle_limit && night) begin
			pump = 1'b0;
			watering = 1'b0;
		end else if (!watering) begin
			pump = 1'b1;
			watering = 1'b1;
			pump_stamp = s.now_ms;
		end else begin
			since = s.now_ms - pump_stamp;
			if (pump) begin
				if (since >= 32'(settings.pump_run_ms)) begin
					pump = 1'b0;
					pump_stamp = s.now_ms;
				end
			end else if (since >= 32'(settings.pump_rest_ms)) begin
				pump = 1'b1;
				pump_stamp = s.now_ms;
			end
		end

		humid = held_hum > settings.air_humidity_limit;
		r.heater_on  = heat | humid;
		r.fan_on     = cool | humid;
		r.pump_on    = pump;
		r.lamp_on    = (s.light_level < settings.light_threshold) &&
			(hour >= 5'(LAMP_HOUR_ON)) && (hour < 5'(LAMP_HOUR_OFF));
		r.hour_now   = hour;
		r.minute_now = minute;
		return r;
	endfunction

	task automatic check_drive(result_t want);
		if (drive.heater_on !== want.heater_on)
			report($sformatf("heater_on expected %0b got %0b", want.heater_on, drive.heater_on));
		if (drive.fan_on !== want.fan_on)
			report($sformatf("fan_on expected %0b got %0b", want.fan_on, drive.fan_on));
		if (drive.pump_on !== want.pump_on)
			report($sformatf("pump_on expected %0b got %0b", want.pump_on, drive.pump_on));
		if (drive.lamp_on !== want.lamp_on)
			report($sformatf("lamp_on expected %0b got %0b", want.lamp_on, drive.lamp_on));
		if (drive.hour_now !== want.hour_now)
			report($sformatf("hour_now expected %0d got %0d", want.hour_now, drive.hour_now));
		if (drive.minute_now !== want.minute_now)
			report($sformatf("minute_now expected %0d got %0d", want.minute_now,
				drive.minute_now));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settings.temp_high          = TEMP_HIGH_RST;
			settings.temp_low           = TEMP_LOW_RST;
			settings.light_threshold    = LIGHT_THR_RST;
			settings.air_humidity_limit = HUM_LIMIT_RST;
			settings.soil_idle_limit    = SOIL_IDLE_RST;
			settings.pump_run_ms        = PUMP_RUN_RST;
			settings.pump_rest_ms       = PUMP_REST_RST;
			held_temp    = HELD_TEMP_RST;
			held_hum     = HELD_HUM_RST;
			minute_stamp = '0;
			pump_stamp   = '0;
			minute       = '0;
			hour         = '0;
			watering     = 1'b0;
			pump         = 1'b0;
			expected_drives.delete();
			pending_drives <= 0;
		end else begin
			// Writes to an index outside the register list change nothing.
			if (wr_en) begin
				case (wr_index)
					REG_TEMP_HIGH: settings.temp_high          = wr_data[7:0];
					REG_TEMP_LOW:  settings.temp_low           = wr_data[7:0];
					REG_LIGHT_THR: settings.light_threshold    = wr_data[9:0];
					REG_HUM_LIMIT: settings.air_humidity_limit = wr_data[6:0];
					REG_SOIL_IDLE: settings.soil_idle_limit    = wr_data[9:0];
					REG_PUMP_RUN:  settings.pump_run_ms        = wr_data[15:0];
					REG_PUMP_REST: settings.pump_rest_ms       = wr_data[15:0];
					default: ;
				endcase
			end
			if (drive.valid && drive.ready) begin
				if (expected_drives.size() == 0)
					report("drive word with no sample waiting for it");
				else
					check_drive(expected_drives.pop_front());
			end
			if (sample.valid && sample.ready)
				expected_drives.push_back(climate_decide('{
					now_ms:             sample.now_ms,
					temperature:        sample.temperature,
					temperature_valid:  sample.temperature_valid,
					air_humidity:       sample.air_humidity,
					air_humidity_valid: sample.air_humidity_valid,
					soil_moisture:      sample.soil_moisture,
					light_level:        sample.light_level}));
			pending_drives <= expected_drives.size();
		end
	end

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// Greenhouse climate controller testbench
// Drives sample words and register writes into the controller with random
// gaps and output stalls; the checker beside the block predicts every drive
// word. A short directed part covers thresholds, invalid readings, pump
// interval edges and timestamp wrap; random words then walk the clock from
// midnight into the lamp hours under default, random and extreme settings.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gcc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] UNUSED_REG = '1;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;
	int                    pending;
	int                    mismatches;
	int                    src_gap_pct;
	int                    sink_stall_pct;
	logic [31:0]           stamp;

	gcc_in_if  sample_ch ();
	gcc_out_if drive_ch ();

	greenhouse_climate_controller DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample_ch),
		.drive    (drive_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	climate_checker watch (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample         (sample_ch),
		.drive          (drive_ch),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.pending_drives (pending),
		.mismatches     (mismatches)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		drive_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	function automatic sample_t mk(logic [31:0] now, logic signed [7:0] temp, logic tv,
		logic [6:0] hum, logic hv, logic [9:0] soil, logic [9:0] light);
		return '{now_ms: now, temperature: temp, temperature_valid: tv, air_humidity: hum,
			air_humidity_valid: hv, soil_moisture: soil, light_level: light};
	endfunction

	// Mostly minute-sized steps so the clock keeps moving, with short steps
	// for the pump intervals and an occasional jump anywhere.
	function automatic sample_t random_sample();
		sample_t s;
		int      pick;
		pick = $urandom_range(99);
		if (pick < 90)
			stamp = stamp + 32'($urandom_range(66000, 60000));
		else if (pick < 97)
			stamp = stamp + 32'($urandom_range(4500));
		else
			stamp = $urandom();
		s.now_ms             = stamp;
		s.temperature        = ($urandom_range(4) == 0) ? 8'($urandom()) :
			8'($urandom_range(120) - 40);
		s.temperature_valid  = ($urandom_range(6) != 0);
		s.air_humidity       = ($urandom_range(4) == 0) ? 7'($urandom()) :
			7'($urandom_range(100));
		s.air_humidity_valid = ($urandom_range(6) != 0);
		s.soil_moisture      = ($urandom_range(2) == 0) ? 10'($urandom_range(150)) :
			10'($urandom());
		s.light_level        = 10'($urandom());
		return s;
	endfunction

	task automatic send_sample(sample_t s);
		while ($urandom_range(99) < src_gap_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid              <= 1'b1;
		sample_ch.now_ms             <= s.now_ms;
		sample_ch.temperature        <= s.temperature;
		sample_ch.temperature_valid  <= s.temperature_valid;
		sample_ch.air_humidity       <= s.air_humidity;
		sample_ch.air_humidity_valid <= s.air_humidity_valid;
		sample_ch.soil_moisture      <= s.soil_moisture;
		sample_ch.light_level        <= s.light_level;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
	endtask

	// Stops the sample stream and lets every predicted drive word come out.
	task automatic drain();
		sample_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
	endtask

	// A write to an unused index is slipped in; it must leave every setting alone.
	task automatic load_settings(logic [CFG_DATA_W-1:0] t_high, logic [CFG_DATA_W-1:0] t_low,
		logic [CFG_DATA_W-1:0] light, logic [CFG_DATA_W-1:0] hum,
		logic [CFG_DATA_W-1:0] soil, logic [CFG_DATA_W-1:0] run,
		logic [CFG_DATA_W-1:0] rest);
		write_reg(REG_TEMP_HIGH, t_high);
		write_reg(REG_TEMP_LOW, t_low);
		write_reg(UNUSED_REG, 16'($urandom()));
		write_reg(REG_LIGHT_THR, light);
		write_reg(REG_HUM_LIMIT, hum);
		write_reg(REG_SOIL_IDLE, soil);
		write_reg(REG_PUMP_RUN, run);
		write_reg(REG_PUMP_REST, rest);
		wr_en <= 1'b0;
	endtask

	task automatic random_run(int n);
		repeat (n) send_sample(random_sample());
		drain();
	endtask

	initial begin
		arst_n                       = 1'b0;
		wr_en                        = 1'b0;
		wr_index                     = '0;
		wr_data                      = '0;
		sample_ch.valid              = 1'b0;
		sample_ch.now_ms             = '0;
		sample_ch.temperature        = '0;
		sample_ch.temperature_valid  = 1'b0;
		sample_ch.air_humidity       = '0;
		sample_ch.air_humidity_valid = 1'b0;
		sample_ch.soil_moisture      = '0;
		sample_ch.light_level        = '0;
		drive_ch.ready               = 1'b0;
		src_gap_pct                  = 16;
		sink_stall_pct               = 71;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words under the reset settings.
		send_sample(mk(32'd0,     8'sd127,  1'b1, 7'd127, 1'b1, 10'd0,    10'd0));
		send_sample(mk(32'd59999, -8'sd128, 1'b1, 7'd0,   1'b1, 10'd1023, 10'd1023));
		send_sample(mk(32'd60000, 8'sd80,   1'b0, 7'd100, 1'b0, 10'd1023, 10'd499));
		send_sample(mk(32'd61998, 8'sd29,   1'b1, 7'd60,  1'b1, 10'd101,  10'd500));
		send_sample(mk(32'd61999, 8'sd28,   1'b1, 7'd61,  1'b1, 10'd101,  10'd0));
		send_sample(mk(32'd65998, 8'sd27,   1'b1, 7'd50,  1'b1, 10'd512,  10'd0));
		send_sample(mk(32'd65999, 8'sd30,   1'b1, 7'd50,  1'b1, 10'd512,  10'd0));
		send_sample(mk(32'd66000, 8'sd30,   1'b1, 7'd50,  1'b1, 10'd100,  10'd0));
		send_sample(mk(32'd66001, -8'sd40,  1'b1, 7'd0,   1'b1, 10'd101,  10'd1));
		send_sample(mk(32'hFFFF_FFF0, 8'sd80, 1'b1, 7'd100, 1'b1, 10'd700, 10'd300));
		send_sample(mk(32'h0000_0100, 8'sd0,  1'b1, 7'd99,  1'b1, 10'd700, 10'd300));
		send_sample(mk(32'hFFFF_FFFF, 8'sd0,  1'b0, 7'd0,   1'b0, 10'd0,   10'd1022));
		send_sample(mk(32'h0000_EA5E, 8'sd5,  1'b1, 7'd1,   1'b1, 10'd1000, 10'd0));
		drain();

		// Inverted thresholds and zero pump times, then a repeat at the other extreme.
		load_settings(16'(-40), 16'd80, 16'd1023, 16'd0, 16'd1023, 16'd0, 16'd0);
		send_sample(mk(32'h0001_0000, 8'sd10,  1'b1, 7'd0, 1'b1, 10'd1023, 10'd1022));
		send_sample(mk(32'h0001_0000, -8'sd41, 1'b1, 7'd1, 1'b1, 10'd1023, 10'd1023));
		send_sample(mk(32'h0001_0001, 8'sd80,  1'b1, 7'd0, 1'b1, 10'd1024 - 10'd1, 10'd0));
		drain();
		load_settings(16'd80, 16'(-40), 16'd0, 16'd100, 16'd0, 16'hFFFF, 16'hFFFF);
		send_sample(mk(32'h0002_0000, 8'sd81,  1'b1, 7'd100, 1'b1, 10'd0, 10'd0));
		send_sample(mk(32'h0002_FFFE, -8'sd41, 1'b1, 7'd101, 1'b1, 10'd1, 10'd0));
		send_sample(mk(32'h0002_FFFF, 8'sd80,  1'b1, 7'd127, 1'b1, 10'd1, 10'd0));
		drain();
		load_settings(16'(TEMP_HIGH_RST), 16'(TEMP_LOW_RST), 16'(LIGHT_THR_RST),
			16'(HUM_LIMIT_RST), 16'(SOIL_IDLE_RST), PUMP_RUN_RST, PUMP_REST_RST);

		// Random words; the clock moves about a minute per word, so it runs from
		// the night hours into the lamp window by the end.
		stamp = 32'h0003_0000;
		random_run(250);
		load_settings(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
			16'($urandom()), 16'($urandom()), 16'($urandom()));
		random_run(100);

		src_gap_pct    = 71;
		sink_stall_pct <= 16;
		load_settings(16'(-40), 16'd80, 16'd1023, 16'd0, 16'd1023, 16'd0, 16'd0);
		random_run(120);
		load_settings(16'($urandom()), 16'($urandom()), 16'($urandom_range(1023)),
			16'($urandom_range(100)), 16'($urandom_range(1023)), 16'($urandom_range(5000)),
			16'($urandom_range(5000)));
		random_run(60);

		src_gap_pct    = 0;
		sink_stall_pct <= 0;
		load_settings(16'd80, 16'(-40), 16'd0, 16'd100, 16'd0, 16'hFFFF, 16'hFFFF);
		random_run(70);
		load_settings(16'(TEMP_HIGH_RST), 16'(TEMP_LOW_RST), 16'd1000, 16'(HUM_LIMIT_RST),
			16'd400, 16'd1500, 16'd2500);
		random_run(80);

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
